FILE: design/binary_to_decimal_seven_segment_core_macros.svh
// Assertion macros used by the checker file of the seven-segment core.
`ifndef BINARY_TO_DECIMAL_SEVEN_SEGMENT_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_SEVEN_SEGMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BDSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdss assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdss assertion failed");

`endif

FILE: design/bdss_pkg.sv
// Shared types, constants and functions of the seven-segment core.
package bdss_pkg;

    localparam int VALUE_W     = 20;
    localparam int POS_W       = 3;
    localparam int SEG_W       = 7;
    localparam int DIGITS_DEF  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 20'd999999;

    // ceil(2^23 / 10); exact quotient for every 20-bit value
    localparam logic [VALUE_W-1:0] RECIP_10   = 20'd838861;
    localparam int                 RECIP_SHIFT = 23;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SEG_W-1:0]   seg_t;

    typedef struct packed {
        logic   valid;
        value_t value;
    } beat_t;

    function automatic seg_t seg_of(input logic [3:0] digit);
        seg_t pattern;
        case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

    function automatic value_t div10(input value_t v);
        logic [2*VALUE_W-1:0] prod;
        prod = {{VALUE_W{1'b0}}, v} * {{VALUE_W{1'b0}}, RECIP_10};
        return VALUE_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

FILE: design/bdss_front.sv
// Front stage: accept values, drop out-of-range ones, hand the rest to the queue.
module bdss_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bdss_pkg::value_t      value,
    output logic                  full,
    output bdss_pkg::beat_t       q_beat,
    input  logic                  q_ready
);
    import bdss_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    logic   advance;
    logic   in_range;

    assign in_range = (value <= VALUE_MAX);
    // advance when the stage is empty or the queue takes its beat
    assign advance  = !valid_reg || q_ready;
    assign full     = !advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = push && in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            value_reg <= value;
        end
    end

    assign q_beat.valid = valid_reg;
    assign q_beat.value = value_reg;

endmodule

FILE: design/bdss_queue.sv
// Short value queue between the front and back stages.
module bdss_queue #(
    parameter int DEPTH = bdss_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bdss_pkg::beat_t in_beat,
    output logic            in_ready,
    output bdss_pkg::beat_t out_beat,
    input  logic            out_pop
);
    import bdss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    value_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign in_ready       = (count_reg != CNT_FULL);
    assign do_wr          = in_beat.valid && in_ready;
    assign do_rd          = out_pop && (count_reg != '0);
    assign out_beat.valid = (count_reg != '0);
    assign out_beat.value = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= in_beat.value;
        end
    end

endmodule

FILE: design/bdss_back.sv
// Back stage: peel one decimal digit per cycle while the result register can advance, and drive the result register.
module bdss_back #(
    parameter int DIGITS = bdss_pkg::DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bdss_pkg::beat_t q_beat,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output bdss_pkg::pos_t  digit_position,
    output bdss_pkg::seg_t  segments,
    output logic            last
);
    import bdss_pkg::*;

    localparam pos_t LAST_POS = POS_W'(DIGITS - 1);

    logic   busy_reg;
    logic   busy_next;
    value_t rem_reg;
    pos_t   pos_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    pos_t   out_pos_reg;
    seg_t   out_seg_reg;
    logic   out_last_reg;

    logic   advance;
    logic   step;
    value_t src_value;
    pos_t   src_pos;
    value_t quotient;
    value_t times_ten;
    value_t diff;
    logic [3:0] digit;

    assign advance   = !out_valid_reg || pop;
    assign step      = advance && (busy_reg || q_beat.valid);
    assign q_pop     = advance && !busy_reg && q_beat.valid;

    assign src_value = busy_reg ? rem_reg : q_beat.value;
    assign src_pos   = busy_reg ? pos_reg : LAST_POS;
    assign quotient  = div10(src_value);
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign diff      = src_value - times_ten;
    assign digit     = diff[3:0];

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            busy_next      = (src_pos != '0);
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rem_reg      <= quotient;
            pos_reg      <= src_pos - 1'b1;
            out_pos_reg  <= src_pos;
            out_seg_reg  <= seg_of(digit);
            out_last_reg <= (src_pos == '0);
        end
    end

    assign empty          = !out_valid_reg;
    assign digit_position = out_pos_reg;
    assign segments       = out_seg_reg;
    assign last           = out_last_reg;

endmodule

FILE: design/binary_to_decimal_seven_segment_core.sv
// Top level of the binary to decimal seven-segment core.
//
// Push a 20-bit binary value; the core emits DIGITS results, one per decimal
// digit, least significant digit first. The first result carries position
// DIGITS-1 and the last carries position 0 with last set. Each result holds
// the seven-segment pattern of its digit (bit 0 is segment a, bit 6 is g);
// leading zeros show as 0 and only the low DIGITS decimal digits appear.
// A value above 999999 is accepted and dropped without any result.
// Each in-range value yields DIGITS results (6 by default), one result per
// cycle while pop keeps up, set by the single divide-by-ten step in the back
// stage; the next value starts only after the last digit of the one before.
// A push reaches the first result through the front register, the queue
// and the result register. A two-entry queue sits between front and back,
// so push keeps flowing while results wait. The result ports form the head
// of the output queue: hold them while empty is low and pop is low.
module binary_to_decimal_seven_segment_core #(
    parameter int DIGITS      = bdss_pkg::DIGITS_DEF,
    parameter int QUEUE_DEPTH = bdss_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  bdss_pkg::value_t value,
    output logic             empty,
    input  logic             pop,
    output bdss_pkg::pos_t   digit_position,
    output bdss_pkg::seg_t   segments,
    output logic             last
);
    import bdss_pkg::*;

    beat_t front_beat;   // front stage to queue
    logic  queue_ready;
    beat_t queue_beat;   // queue head to back stage
    logic  queue_pop;

    // Accept and classify: out-of-range values are dropped here.
    bdss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .value   (value),
        .full    (full),
        .q_beat  (front_beat),
        .q_ready (queue_ready)
    );

    // Decouple the front from the digit loop.
    bdss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (front_beat),
        .in_ready (queue_ready),
        .out_beat (queue_beat),
        .out_pop  (queue_pop)
    );

    // Split into digits and decode, one beat out per cycle while pop allows.
    bdss_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_beat         (queue_beat),
        .q_pop          (queue_pop),
        .empty          (empty),
        .pop            (pop),
        .digit_position (digit_position),
        .segments       (segments),
        .last           (last)
    );

endmodule

FILE: design/bdss_checker.sv
// Port-level checker for the seven-segment core and its bind.
`include "binary_to_decimal_seven_segment_core_macros.svh"

module bdss_checker #(
    parameter int DIGITS = bdss_pkg::DIGITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input bdss_pkg::pos_t digit_position,
    input bdss_pkg::seg_t segments,
    input logic           last
);
    import bdss_pkg::*;

    localparam pos_t LAST_POS = POS_W'(DIGITS - 1);

    logic held;
    logic moved_on;
    pos_t next_pos;

    assign held     = !empty && !pop;
    assign moved_on = !empty && pop && !last;
    assign next_pos = digit_position - 1'b1;

    // a stalled result beat holds its payload
    `BDSS_ASSERT_NEXT(a_hold, clk, rst_n, held, !empty && $stable({digit_position, segments, last}))
    // last flags exactly position 0
    `BDSS_ASSERT_NOW(a_last, clk, rst_n, !empty, last == (digit_position == '0))
    // position never exceeds the display width
    `BDSS_ASSERT_NOW(a_range, clk, rst_n, !empty, digit_position <= LAST_POS)
    // within a run the next digit follows at once, one position lower
    `BDSS_ASSERT_NEXT(a_run, clk, rst_n, moved_on, !empty && digit_position == $past(next_pos))

endmodule

bind binary_to_decimal_seven_segment_core bdss_checker #(
    .DIGITS (DIGITS)
) u_bdss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .digit_position (digit_position),
    .segments       (segments),
    .last           (last)
);
